### rtl/servo_command_to_pwm_compare_assert.svh
// ----------------------------------------------------------------------------
// Servo compare unit assertion macros
// Shared property forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_TO_PWM_COMPARE_ASSERT_SVH
`define SERVO_COMMAND_TO_PWM_COMPARE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SVCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SVCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/svcp_pkg.sv
// ----------------------------------------------------------------------------
// Servo compare unit package
// Field widths, command and register codes, shared types and clamp helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svcp_pkg;

   localparam int CMD_W      = 3;
   localparam int ANGLE_W    = 8;
   localparam int CMP_W      = 16;
   localparam int PULSE_W    = 15;
   localparam int PW_W       = 16;
   localparam int PCT_W      = 8;
   localparam int IVL_W      = 16;
   localparam int PROD_W     = ANGLE_W + CMP_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET_ANGLE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_PULSE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_SPEED = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWEEP     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SAFE_MIN   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAFE_MAX   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CMP_BASE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CMP_SPAN   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_MIN  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_MAX  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_STOP = 3'd6;

   // register reset values
   localparam logic [ANGLE_W-1:0] RST_SAFE_MIN   = 8'd0;
   localparam logic [ANGLE_W-1:0] RST_SAFE_MAX   = 8'd180;
   localparam logic [CMP_W-1:0]   RST_CMP_BASE   = 16'd1000;
   localparam logic [CMP_W-1:0]   RST_CMP_SPAN   = 16'd4000;
   localparam logic [PULSE_W-1:0] RST_PULSE_MIN  = 15'd500;
   localparam logic [PULSE_W-1:0] RST_PULSE_MAX  = 15'd2500;
   localparam logic [PULSE_W-1:0] RST_PULSE_STOP = 15'd1500;

   // speed saturation, in percent
   localparam logic signed [PCT_W-1:0] SPEED_LIMIT = 8'sd100;

   // how the compare value of an item is formed
   typedef enum logic [1:0] {
      KIND_HOLD,
      KIND_ANGLE,
      KIND_PULSE
   } kind_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] safe_min_angle;
      logic [ANGLE_W-1:0] safe_max_angle;
      logic [CMP_W-1:0]   compare_base;
      logic [CMP_W-1:0]   compare_span;
      logic [PULSE_W-1:0] pulse_min_us;
      logic [PULSE_W-1:0] pulse_max_us;
      logic [PULSE_W-1:0] pulse_stop_us;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [ANGLE_W-1:0]      angle;
      logic [PW_W-1:0]         pulse_width_us;
      logic signed [PCT_W-1:0] speed_percent;
      logic [IVL_W-1:0]        step_interval_ms;
   } item_type;

   // per-item result of the state update
   typedef struct packed {
      kind_type           kind;
      logic [ANGLE_W-1:0] apply_angle;
      logic [CMP_W-1:0]   pulse_cmp;
      logic [ANGLE_W-1:0] cur_angle;
      logic               sweeping;
   } upd_type;

   // live controller state
   typedef struct packed {
      logic [ANGLE_W-1:0] cur_angle;
      logic               sweep_active;
   } stat_type;

   // upper limit first, then lower; a is one bit wider to take angle + 1
   function automatic logic [ANGLE_W-1:0] clamp_angle(
      input logic [ANGLE_W:0]   a,
      input logic [ANGLE_W-1:0] lo,
      input logic [ANGLE_W-1:0] hi
   );
      logic [ANGLE_W:0] y;
      y = (a > {1'b0, hi}) ? {1'b0, hi} : a;
      y = (y < {1'b0, lo}) ? {1'b0, lo} : y;
      return y[ANGLE_W-1:0];
   endfunction

   // lower limit first, then upper; returns twice the width, 16-bit wrap
   function automatic logic [CMP_W-1:0] pulse_compare(
      input logic [PW_W-1:0]    p,
      input logic [PULSE_W-1:0] lo,
      input logic [PULSE_W-1:0] hi
   );
      logic [PW_W-1:0] y;
      y = (p < {1'b0, lo}) ? {1'b0, lo} : p;
      y = (y > {1'b0, hi}) ? {1'b0, hi} : y;
      return {y[PW_W-2:0], 1'b0};
   endfunction

endpackage

### rtl/svcp_ctrl.sv
// ----------------------------------------------------------------------------
// Servo compare unit controller
// Holds angle and sweep state and works out each item's state update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svcp_ctrl #(
   parameter int ANGLE_CENTER = 90
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               upd_en,
   input  svcp_pkg::item_type item,
   input  svcp_pkg::cfg_type  cfg,
   output svcp_pkg::upd_type  upd,
   output svcp_pkg::stat_type stat
);

   logic [svcp_pkg::ANGLE_W-1:0] cur_ff, cur_in;
   logic [svcp_pkg::ANGLE_W-1:0] target_ff, target_in;
   logic [svcp_pkg::IVL_W-1:0]   interval_ff, interval_in;
   logic [svcp_pkg::IVL_W-1:0]   countdown_ff, countdown_in;
   logic                         active_ff, active_in;
   logic                         upward_ff, upward_in;

   logic [svcp_pkg::ANGLE_W-1:0]     clamp_req;
   logic [svcp_pkg::ANGLE_W-1:0]     clamp_cur;
   logic [svcp_pkg::ANGLE_W-1:0]     clamp_step;
   logic [svcp_pkg::ANGLE_W:0]       step_angle;
   logic signed [svcp_pkg::PCT_W-1:0] pct_sat;
   logic [svcp_pkg::PW_W-1:0]        pct_ext;
   logic [svcp_pkg::PW_W-1:0]        speed_width;

   // shared clamps and speed mapping
   always_comb begin
      clamp_req = svcp_pkg::clamp_angle({1'b0, item.angle},
                                        cfg.safe_min_angle, cfg.safe_max_angle);
      clamp_cur = svcp_pkg::clamp_angle({1'b0, cur_ff},
                                        cfg.safe_min_angle, cfg.safe_max_angle);
      if (upward_ff) begin
         step_angle = {1'b0, cur_ff} + 9'd1;
      end else if (cur_ff != '0) begin
         step_angle = {1'b0, cur_ff} - 9'd1;
      end else begin
         step_angle = '0;
      end
      clamp_step = svcp_pkg::clamp_angle(step_angle,
                                         cfg.safe_min_angle, cfg.safe_max_angle);

      if (item.speed_percent > svcp_pkg::SPEED_LIMIT) begin
         pct_sat = svcp_pkg::SPEED_LIMIT;
      end else if (item.speed_percent < -svcp_pkg::SPEED_LIMIT) begin
         pct_sat = -svcp_pkg::SPEED_LIMIT;
      end else begin
         pct_sat = item.speed_percent;
      end
      // width = stop - 5 * percent, modulo 2^16
      pct_ext     = {{(svcp_pkg::PW_W - svcp_pkg::PCT_W){pct_sat[svcp_pkg::PCT_W-1]}},
                     pct_sat};
      speed_width = {1'b0, cfg.pulse_stop_us} - ((pct_ext << 2) + pct_ext);
   end

   // next state per command
   always_comb begin
      cur_in       = cur_ff;
      target_in    = target_ff;
      interval_in  = interval_ff;
      countdown_in = countdown_ff;
      active_in    = active_ff;
      upward_in    = upward_ff;
      upd.kind        = svcp_pkg::KIND_HOLD;
      upd.apply_angle = cur_ff;
      upd.pulse_cmp   = '0;

      unique case (item.cmd)
         svcp_pkg::CMD_SET_ANGLE: begin
            active_in       = 1'b0;
            cur_in          = clamp_req;
            upd.kind        = svcp_pkg::KIND_ANGLE;
            upd.apply_angle = clamp_req;
         end
         svcp_pkg::CMD_SET_PULSE: begin
            active_in     = 1'b0;
            upd.kind      = svcp_pkg::KIND_PULSE;
            upd.pulse_cmp = svcp_pkg::pulse_compare(item.pulse_width_us,
                                                    cfg.pulse_min_us, cfg.pulse_max_us);
         end
         svcp_pkg::CMD_STOP: begin
            active_in     = 1'b0;
            upd.kind      = svcp_pkg::KIND_PULSE;
            upd.pulse_cmp = svcp_pkg::pulse_compare({1'b0, cfg.pulse_stop_us},
                                                    cfg.pulse_min_us, cfg.pulse_max_us);
         end
         svcp_pkg::CMD_SET_SPEED: begin
            active_in     = 1'b0;
            upd.kind      = svcp_pkg::KIND_PULSE;
            upd.pulse_cmp = svcp_pkg::pulse_compare(speed_width,
                                                    cfg.pulse_min_us, cfg.pulse_max_us);
         end
         svcp_pkg::CMD_SWEEP: begin
            active_in = 1'b0;
            if (cur_ff == clamp_req) begin
               // already there: only the cancel takes effect
               upd.kind = svcp_pkg::KIND_HOLD;
            end else if (item.step_interval_ms == '0) begin
               cur_in          = clamp_req;
               upd.kind        = svcp_pkg::KIND_ANGLE;
               upd.apply_angle = clamp_req;
            end else begin
               upward_in       = cur_ff < clamp_req;
               target_in       = clamp_req;
               interval_in     = item.step_interval_ms;
               countdown_in    = item.step_interval_ms;
               cur_in          = clamp_cur;
               upd.kind        = svcp_pkg::KIND_ANGLE;
               upd.apply_angle = clamp_cur;
               active_in       = clamp_cur != clamp_req;
            end
         end
         svcp_pkg::CMD_TICK: begin
            if (active_ff) begin
               if (countdown_ff > 16'd1) begin
                  countdown_in = countdown_ff - 16'd1;
               end else begin
                  cur_in          = clamp_step;
                  upd.kind        = svcp_pkg::KIND_ANGLE;
                  upd.apply_angle = clamp_step;
                  // done at the target, or when the limits pin the angle
                  if (clamp_step == target_ff || clamp_step == cur_ff) begin
                     active_in = 1'b0;
                  end else begin
                     countdown_in = interval_ff;
                  end
               end
            end
         end
         default: begin
            upd.kind = svcp_pkg::KIND_HOLD;
         end
      endcase

      upd.cur_angle = cur_in;
      upd.sweeping  = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= svcp_pkg::ANGLE_W'(ANGLE_CENTER);
         target_ff    <= '0;
         interval_ff  <= '0;
         countdown_ff <= '0;
         active_ff    <= 1'b0;
         upward_ff    <= 1'b0;
      end else if (upd_en) begin
         cur_ff       <= cur_in;
         target_ff    <= target_in;
         interval_ff  <= interval_in;
         countdown_ff <= countdown_in;
         active_ff    <= active_in;
         upward_ff    <= upward_in;
      end
   end

   assign stat.cur_angle    = cur_ff;
   assign stat.sweep_active = active_ff;

endmodule

### rtl/svcp_scale.sv
// ----------------------------------------------------------------------------
// Servo compare unit scaler
// Divides angle * span by the full-scale angle with an exact reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svcp_scale #(
   parameter int ANGLE_FULL_SCALE = 180
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [svcp_pkg::PROD_W-1:0]   prod,
   output logic [svcp_pkg::CMP_W-1:0]    quot_ff
);

   // m = ceil(2^s / d) with s = PROD_W + ceil(log2 d) is exact for any
   // dividend below 2^PROD_W
   localparam int RECIP_L = $clog2(ANGLE_FULL_SCALE);
   localparam int SHIFT   = svcp_pkg::PROD_W + RECIP_L;
   localparam int RECIP_W = svcp_pkg::PROD_W + 2;
   localparam int MUL_W   = svcp_pkg::PROD_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(ANGLE_FULL_SCALE) - 64'd1) / 64'(ANGLE_FULL_SCALE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic [MUL_W-1:0] mul;

   assign mul = MUL_W'(prod) * MUL_W'(RECIP);

   // only the low quotient bits survive the 16-bit compare wrap
   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= mul[SHIFT +: svcp_pkg::CMP_W];
      end
   end

endmodule

### rtl/servo_command_to_pwm_compare.sv
// Throughput: one command per cycle unless the result channel stalls; the four-stage
// pipeline advances whenever the next stage is free, so earlier stages take input while
// a result waits, until they are full.
// Stages: input register, state update with angle * span, reciprocal multiply, output.
// Reset (synchronous): registers to defaults, angle to center, pipeline empty.
// ----------------------------------------------------------------------------
// Servo command to PWM compare
// Turns servo commands and millisecond ticks into a 16-bit timer compare value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_command_to_pwm_compare #(
   parameter int ANGLE_FULL_SCALE = 180,
   parameter int ANGLE_CENTER     = 90
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] angle, [23:8] pulse_width_us, [31:24] speed_percent,
   // [47:32] step_interval_ms
   input  logic [47:0]                        req_tdata,
   // [2:0] cmd
   input  logic [svcp_pkg::CMD_W-1:0]         req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] compare_value, [23:16] current_angle_out, [24] sweeping, [31:25] zero
   output logic [31:0]                        rsp_tdata,
   // register write port
   input  logic                               csr_we,
   input  logic [svcp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [svcp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

`include "servo_command_to_pwm_compare_assert.svh"

   localparam logic [svcp_pkg::CMP_W-1:0] CENTER_CMP = svcp_pkg::CMP_W'(
      (ANGLE_CENTER * int'(svcp_pkg::RST_CMP_SPAN)) / ANGLE_FULL_SCALE
      + int'(svcp_pkg::RST_CMP_BASE));

   svcp_pkg::cfg_type  cfg_ff;
   svcp_pkg::item_type item_ff;
   svcp_pkg::upd_type  upd;
   svcp_pkg::stat_type stat;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready1, ready2, ready3, ready4;
   logic accept, move12, move23, move34;

   svcp_pkg::kind_type               s2_kind_ff, s3_kind_ff;
   logic [svcp_pkg::CMP_W-1:0]       s2_pcmp_ff, s3_pcmp_ff;
   logic [svcp_pkg::ANGLE_W-1:0]     s2_angle_ff, s3_angle_ff;
   logic                             s2_sweep_ff, s3_sweep_ff;
   logic [svcp_pkg::PROD_W-1:0]      s2_prod_ff, s2_prod_in;
   logic [svcp_pkg::CMP_W-1:0]       s3_quot;

   logic [svcp_pkg::CMP_W-1:0]       rsp_cmp_ff, rsp_cmp_in;
   logic [svcp_pkg::ANGLE_W-1:0]     rsp_angle_ff;
   logic                             rsp_sweep_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.safe_min_angle <= svcp_pkg::RST_SAFE_MIN;
         cfg_ff.safe_max_angle <= svcp_pkg::RST_SAFE_MAX;
         cfg_ff.compare_base   <= svcp_pkg::RST_CMP_BASE;
         cfg_ff.compare_span   <= svcp_pkg::RST_CMP_SPAN;
         cfg_ff.pulse_min_us   <= svcp_pkg::RST_PULSE_MIN;
         cfg_ff.pulse_max_us   <= svcp_pkg::RST_PULSE_MAX;
         cfg_ff.pulse_stop_us  <= svcp_pkg::RST_PULSE_STOP;
      end else if (csr_we) begin
         unique case (csr_addr)
            svcp_pkg::CSR_SAFE_MIN:   cfg_ff.safe_min_angle <= csr_wdata[7:0];
            svcp_pkg::CSR_SAFE_MAX:   cfg_ff.safe_max_angle <= csr_wdata[7:0];
            svcp_pkg::CSR_CMP_BASE:   cfg_ff.compare_base   <= csr_wdata;
            svcp_pkg::CSR_CMP_SPAN:   cfg_ff.compare_span   <= csr_wdata;
            svcp_pkg::CSR_PULSE_MIN:  cfg_ff.pulse_min_us   <= csr_wdata[14:0];
            svcp_pkg::CSR_PULSE_MAX:  cfg_ff.pulse_max_us   <= csr_wdata[14:0];
            svcp_pkg::CSR_PULSE_STOP: cfg_ff.pulse_stop_us  <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control: a stage moves on when the next one is free
   assign ready4     = !v4_ff || rsp_tready;
   assign move34     = v3_ff && ready4;
   assign ready3     = !v3_ff || ready4;
   assign move23     = v2_ff && ready3;
   assign ready2     = !v2_ff || ready3;
   assign move12     = v1_ff && ready2;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;
   assign accept     = req_tvalid && ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept || (v1_ff && !move12);
         v2_ff <= move12 || (v2_ff && !move23);
         v3_ff <= move23 || (v3_ff && !move34);
         v4_ff <= move34 || (v4_ff && !rsp_tready);
      end
   end

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd              <= req_tuser;
         item_ff.angle            <= req_tdata[7:0];
         item_ff.pulse_width_us   <= req_tdata[23:8];
         item_ff.speed_percent    <= req_tdata[31:24];
         item_ff.step_interval_ms <= req_tdata[47:32];
      end
   end

   // stage 2: state update
   svcp_ctrl #(
      .ANGLE_CENTER (ANGLE_CENTER)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .upd_en (move12),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .upd    (upd),
      .stat   (stat)
   );

   assign s2_prod_in = svcp_pkg::PROD_W'(upd.apply_angle) *
                       svcp_pkg::PROD_W'(cfg_ff.compare_span);

   always_ff @(posedge clock) begin
      if (move12) begin
         s2_kind_ff  <= upd.kind;
         s2_pcmp_ff  <= upd.pulse_cmp;
         s2_angle_ff <= upd.cur_angle;
         s2_sweep_ff <= upd.sweeping;
         s2_prod_ff  <= s2_prod_in;
      end
   end

   // stage 3: divide by the full-scale angle
   svcp_scale #(
      .ANGLE_FULL_SCALE (ANGLE_FULL_SCALE)
   ) u_scale (
      .clock   (clock),
      .load    (move23),
      .prod    (s2_prod_ff),
      .quot_ff (s3_quot)
   );

   always_ff @(posedge clock) begin
      if (move23) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_pcmp_ff  <= s2_pcmp_ff;
         s3_angle_ff <= s2_angle_ff;
         s3_sweep_ff <= s2_sweep_ff;
      end
   end

   // stage 4: output register; a hold keeps the previous compare value
   always_comb begin
      unique case (s3_kind_ff)
         svcp_pkg::KIND_ANGLE: rsp_cmp_in = s3_quot + cfg_ff.compare_base;
         svcp_pkg::KIND_PULSE: rsp_cmp_in = s3_pcmp_ff;
         default:              rsp_cmp_in = rsp_cmp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_cmp_ff <= CENTER_CMP;
      end else if (move34) begin
         rsp_cmp_ff <= rsp_cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move34) begin
         rsp_angle_ff <= s3_angle_ff;
         rsp_sweep_ff <= s3_sweep_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {7'd0, rsp_sweep_ff, rsp_angle_ff, rsp_cmp_ff};

   // checks
   `SVCP_ASSERT_NEXT(a_state_hold, clock, reset, !move12, $stable(stat),
                     "servo state changed without an item")
   `SVCP_ASSERT_NEXT(a_idle_tick, clock, reset,
                     move12 && item_ff.cmd == svcp_pkg::CMD_TICK && !stat.sweep_active,
                     $stable(stat.cur_angle), "idle tick moved the angle")
   `SVCP_ASSERT_NEXT(a_cancel, clock, reset,
                     move12 && (item_ff.cmd == svcp_pkg::CMD_SET_ANGLE ||
                                item_ff.cmd == svcp_pkg::CMD_SET_PULSE ||
                                item_ff.cmd == svcp_pkg::CMD_STOP ||
                                item_ff.cmd == svcp_pkg::CMD_SET_SPEED),
                     !stat.sweep_active, "command did not cancel the sweep")

endmodule
